/* src/mck_pkg.sv */
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants, letter pattern table and microcode program for
// the morse character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    // register defaults and sizes
    localparam int DATA_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_ELEMENTS    = 5;
    localparam int SLOTS           = 8;
    localparam int SLOT_W          = 3;
    localparam int ROWS            = 27;
    localparam int ROW_W           = 5;

    localparam logic [DATA_W-1:0] DOT_RESET  = 16'd100;
    localparam logic [DATA_W-1:0] DASH_RESET = 16'd300;
    localparam logic [DATA_W-1:0] EGAP_RESET = 16'd200;
    localparam logic [DATA_W-1:0] CGAP_RESET = 16'd100;

    localparam logic [7:0]       ASCII_A   = 8'h41;
    localparam logic [7:0]       ASCII_Z   = 8'h5A;
    localparam logic [ROW_W-1:0] SPACE_ROW = 5'd26;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EGAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CGAP = 2'd3;

    // element codes
    localparam logic [1:0] NON = 2'd0;
    localparam logic [1:0] DOT = 2'd1;
    localparam logic [1:0] DSH = 2'd2;

    // slot 0 is the first element sent
    typedef logic [0:SLOTS-1][1:0] t_row;

    // microcode
    typedef logic [1:0] t_step;
    localparam t_step STEP_FETCH = 2'd0;
    localparam t_step STEP_ELEM  = 2'd1;
    localparam t_step STEP_GAP   = 2'd2;
    localparam t_step STEP_CGAP  = 2'd3;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_ON   = 2'd1,
        EMIT_GAP  = 2'd2,
        EMIT_CHAR = 2'd3
    } t_emit;

    typedef enum logic {
        COND_NONE = 1'b0,
        COND_DONE = 1'b1
    } t_cond;

    typedef struct packed {
        t_emit emit;
        logic  wait_in;
        logic  inc;
        t_cond cond;
        t_step jump;
        t_step next;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic  load;
        t_emit emit;
        logic  inc;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic done;
        logic out_free;
    } t_status;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{emit: EMIT_NONE, wait_in: 1'b1, inc: 1'b0, cond: COND_NONE,
              jump: STEP_FETCH, next: STEP_ELEM};
        case (step)
            STEP_FETCH: w = '{emit: EMIT_NONE, wait_in: 1'b1, inc: 1'b0,
                              cond: COND_NONE, jump: STEP_FETCH, next: STEP_ELEM};
            // branch to the character gap once the pattern is used up
            STEP_ELEM:  w = '{emit: EMIT_ON, wait_in: 1'b0, inc: 1'b0,
                              cond: COND_DONE, jump: STEP_CGAP, next: STEP_GAP};
            STEP_GAP:   w = '{emit: EMIT_GAP, wait_in: 1'b0, inc: 1'b1,
                              cond: COND_NONE, jump: STEP_FETCH, next: STEP_ELEM};
            STEP_CGAP:  w = '{emit: EMIT_CHAR, wait_in: 1'b0, inc: 1'b0,
                              cond: COND_NONE, jump: STEP_FETCH, next: STEP_FETCH};
            default:    w = '{emit: EMIT_NONE, wait_in: 1'b1, inc: 1'b0,
                              cond: COND_NONE, jump: STEP_FETCH, next: STEP_ELEM};
        endcase
        return w;
    endfunction

    function automatic t_row pattern(input logic [ROW_W-1:0] row);
        t_row r;
        r = '0;
        case (row)
            5'd0:    r = {DOT, DSH, NON, NON, NON, NON, NON, NON}; // A
            5'd1:    r = {DSH, DOT, DOT, DOT, NON, NON, NON, NON}; // B
            5'd2:    r = {DSH, DOT, DSH, DOT, NON, NON, NON, NON}; // C
            5'd3:    r = {DSH, DOT, DOT, NON, NON, NON, NON, NON}; // D
            5'd4:    r = {DOT, NON, NON, NON, NON, NON, NON, NON}; // E
            5'd5:    r = {DOT, DOT, DSH, DOT, NON, NON, NON, NON}; // F
            5'd6:    r = {DSH, DSH, DOT, NON, NON, NON, NON, NON}; // G
            5'd7:    r = {DOT, DOT, DOT, DOT, NON, NON, NON, NON}; // H
            5'd8:    r = {DOT, DOT, NON, NON, NON, NON, NON, NON}; // I
            5'd9:    r = {DOT, DSH, DSH, DSH, NON, NON, NON, NON}; // J
            5'd10:   r = {DSH, DOT, DSH, NON, NON, NON, NON, NON}; // K
            5'd11:   r = {DOT, DSH, DOT, DOT, NON, NON, NON, NON}; // L
            5'd12:   r = {DSH, DSH, NON, NON, NON, NON, NON, NON}; // M
            5'd13:   r = {DSH, DOT, NON, NON, NON, NON, NON, NON}; // N
            5'd14:   r = {DSH, DSH, DSH, NON, NON, NON, NON, NON}; // O
            5'd15:   r = {DOT, DSH, DSH, DOT, NON, NON, NON, NON}; // P
            5'd16:   r = {DSH, DSH, DOT, DSH, NON, NON, NON, NON}; // Q
            5'd17:   r = {DOT, DSH, DOT, NON, NON, NON, NON, NON}; // R
            5'd18:   r = {DOT, DOT, DOT, NON, NON, NON, NON, NON}; // S
            5'd19:   r = {DSH, NON, NON, NON, NON, NON, NON, NON}; // T
            5'd20:   r = {DOT, DOT, DSH, NON, NON, NON, NON, NON}; // U
            5'd21:   r = {DOT, DOT, DOT, DSH, NON, NON, NON, NON}; // V
            5'd22:   r = {DOT, DSH, DSH, NON, NON, NON, NON, NON}; // W
            5'd23:   r = {DSH, DOT, DOT, DSH, NON, NON, NON, NON}; // X
            5'd24:   r = {DSH, DOT, DSH, DSH, NON, NON, NON, NON}; // Y
            5'd25:   r = {DSH, DSH, DOT, DOT, NON, NON, NON, NON}; // Z
            default: r = {DSH, DOT, DOT, DOT, DSH, NON, NON, NON}; // word space
        endcase
        return r;
    endfunction

endpackage

/* src/morse_character_keyer_core.sv */
// ----------------------------------------------------------------------------
// morse_character_keyer_core
// Turns one ASCII character into its morse keying as timed key-on/key-off
// segments, driven by a four-step microcode program.
//
//   channel   direction  signals
//   in        sink       i_in_valid / o_in_ready, i_ascii_char
//   out       source     o_out_valid / i_out_ready, o_key_level,
//                        o_duration_ms, o_last_segment
//   cfg       sink       i_cfg_we, i_cfg_index, i_cfg_data
//
// a character with n elements runs through one fetch step, two steps
// per element, one step to see the pattern end and one for the character gap
// the step counter runs one step per cycle; a full output register, or the fetch step without input, stalls it
// synchronous active-low reset restores the default timings and the fetch step
// ----------------------------------------------------------------------------
module morse_character_keyer_core #(
    parameter int MAX_ELEMENTS = mck_pkg::MAX_ELEMENTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_ascii_char,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_key_level,
    output logic [mck_pkg::DATA_W-1:0]    o_duration_ms,
    output logic                          o_last_segment,
    input  logic                          i_cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mck_pkg::DATA_W-1:0]    i_cfg_data
);

    mck_pkg::t_ctrl   w_ctrl;
    mck_pkg::t_status w_status;

    mck_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    mck_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ascii_char   (i_ascii_char),
        .i_ctrl         (w_ctrl),
        .i_out_ready    (i_out_ready),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_key_level    (o_key_level),
        .o_duration_ms  (o_duration_ms),
        .o_last_segment (o_last_segment)
    );

    // a segment is only written when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.emit != mck_pkg::EMIT_NONE) |-> (!o_out_valid || i_out_ready))
        else $error("segment written over a pending transaction");

    // the closing segment is always key off
    a_last_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_segment) |-> !o_key_level)
        else $error("last segment with key on");

    // after a character is taken the sequencer leaves the fetch step
    a_leave_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transaction");

endmodule

/* src/mck_sequencer.sv */
// ----------------------------------------------------------------------------
// mck_sequencer
// Step counter and microcode fetch; resolves the conditional jump and stalls
// on input and output handshakes.
// ----------------------------------------------------------------------------
module mck_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mck_pkg::t_status i_status,
    output logic             o_in_ready,
    output mck_pkg::t_ctrl   o_ctrl
);

    mck_pkg::t_step  r_step;
    mck_pkg::t_step  n_step;
    mck_pkg::t_uword w_uword;
    mck_pkg::t_emit  w_emit;
    logic            w_taken;
    logic            w_go;

    always_comb begin
        w_uword = mck_pkg::ucode(r_step);
        w_taken = (w_uword.cond == mck_pkg::COND_DONE) && i_status.done;
        // a taken jump skips the step's own output
        w_emit  = w_taken ? mck_pkg::EMIT_NONE : w_uword.emit;
        w_go    = (!w_uword.wait_in || i_in_valid) &&
                  ((w_emit == mck_pkg::EMIT_NONE) || i_status.out_free);

        o_in_ready   = w_uword.wait_in;
        o_ctrl.load  = w_uword.wait_in && i_in_valid;
        o_ctrl.emit  = w_go ? w_emit : mck_pkg::EMIT_NONE;
        o_ctrl.inc   = w_go && !w_taken && w_uword.inc;

        if (!w_go) begin
            n_step = r_step;
        end else if (w_taken) begin
            n_step = w_uword.jump;
        end else begin
            n_step = w_uword.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mck_pkg::STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* src/mck_datapath.sv */
// ----------------------------------------------------------------------------
// mck_datapath
// Timing registers, pattern register, element index and the output register
// that holds one segment until it is taken.
// ----------------------------------------------------------------------------
module mck_datapath #(
    parameter int MAX_ELEMENTS = mck_pkg::MAX_ELEMENTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mck_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]                   i_ascii_char,
    input  mck_pkg::t_ctrl               i_ctrl,
    input  logic                         i_out_ready,
    output mck_pkg::t_status             o_status,
    output logic                         o_out_valid,
    output logic                         o_key_level,
    output logic [mck_pkg::DATA_W-1:0]   o_duration_ms,
    output logic                         o_last_segment
);

    localparam int LIMIT  = (MAX_ELEMENTS > mck_pkg::SLOTS) ? mck_pkg::SLOTS : MAX_ELEMENTS;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int IDX_W  = (CNT_W > mck_pkg::SLOT_W) ? CNT_W : mck_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LIMIT_V = IDX_W'(LIMIT);

    logic [mck_pkg::DATA_W-1:0] r_dot;
    logic [mck_pkg::DATA_W-1:0] r_dash;
    logic [mck_pkg::DATA_W-1:0] r_egap;
    logic [mck_pkg::DATA_W-1:0] r_cgap;

    mck_pkg::t_row              r_pat;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_out_valid;
    logic                       r_key;
    logic [mck_pkg::DATA_W-1:0] r_dur;
    logic                       r_last;

    logic [mck_pkg::ROW_W-1:0]  w_row;
    logic [1:0]                 w_code;
    logic [7:0]                 w_ofs;

    always_comb begin
        w_ofs = i_ascii_char - mck_pkg::ASCII_A;
        if (i_ascii_char >= mck_pkg::ASCII_A && i_ascii_char <= mck_pkg::ASCII_Z) begin
            w_row = w_ofs[mck_pkg::ROW_W-1:0];
        end else begin
            w_row = mck_pkg::SPACE_ROW;
        end
        w_code            = r_pat[r_idx[mck_pkg::SLOT_W-1:0]];
        o_status.done     = (r_idx == LIMIT_V) || (w_code == mck_pkg::NON);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= mck_pkg::DOT_RESET;
            r_dash <= mck_pkg::DASH_RESET;
            r_egap <= mck_pkg::EGAP_RESET;
            r_cgap <= mck_pkg::CGAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mck_pkg::REG_DOT:  r_dot  <= i_cfg_data;
                mck_pkg::REG_DASH: r_dash <= i_cfg_data;
                mck_pkg::REG_EGAP: r_egap <= i_cfg_data;
                mck_pkg::REG_CGAP: r_cgap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctrl.load) begin
            r_idx <= '0;
        end else if (i_ctrl.inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pat <= mck_pkg::pattern(w_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit != mck_pkg::EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.emit)
            mck_pkg::EMIT_ON: begin
                r_key  <= 1'b1;
                r_dur  <= (w_code == mck_pkg::DSH) ? r_dash : r_dot;
                r_last <= 1'b0;
            end
            mck_pkg::EMIT_GAP: begin
                r_key  <= 1'b0;
                r_dur  <= r_egap;
                r_last <= 1'b0;
            end
            mck_pkg::EMIT_CHAR: begin
                r_key  <= 1'b0;
                r_dur  <= r_cgap;
                r_last <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_level    = r_key;
    assign o_duration_ms  = r_dur;
    assign o_last_segment = r_last;

endmodule

/* bench/morse_character_keyer_core_tb.sv */
// ----------------------------------------------------------------------------
// morse_character_keyer_core_tb
// Self-checking bench for the morse character keyer. A short table of
// characters runs first at the reset timings. Random characters follow in
// phases, and the timing registers are rewritten between phases: all zero,
// all ones, then random values. Every keying segment that comes out is
// compared against a local model of the letter table and the timing
// registers, or against typed segments. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module morse_character_keyer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ELEM_CAP    = (mck_pkg::MAX_ELEMENTS > mck_pkg::SLOTS) ?
                                 mck_pkg::SLOTS : mck_pkg::MAX_ELEMENTS;
    localparam int WORD_SPACE  = int'(mck_pkg::SPACE_ROW);

    typedef struct packed {
        logic                       level;
        logic [mck_pkg::DATA_W-1:0] dur;
        logic                       last;
    } t_segment;

    typedef struct packed {
        logic [7:0]         ch;
        logic               typed;
        t_segment [0:2]     segs;
    } t_stim_row;

    // {element count, dash mask}; mask bit 4 is the first element, 1 = dash
    localparam logic [7:0] MORSE_CODE [0:26] = '{
        {3'd2, 5'b01000}, {3'd4, 5'b10000}, {3'd4, 5'b10100}, {3'd3, 5'b10000},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b11000}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b10100}, {3'd4, 5'b01000},
        {3'd2, 5'b11000}, {3'd2, 5'b10000}, {3'd3, 5'b11100}, {3'd4, 5'b01100},
        {3'd4, 5'b11010}, {3'd3, 5'b01000}, {3'd3, 5'b00000}, {3'd1, 5'b10000},
        {3'd3, 5'b00100}, {3'd4, 5'b00010}, {3'd3, 5'b01100}, {3'd4, 5'b10010},
        {3'd4, 5'b10110}, {3'd4, 5'b11000}, {3'd5, 5'b10001}
    };

    localparam int N_DIRECTED = 16;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // single dot and single dash at the reset timings
        '{8'h45, 1'b1, '{'{1'b1, 16'd100, 1'b0}, '{1'b0, 16'd200, 1'b0},
                         '{1'b0, 16'd100, 1'b1}}},
        '{8'h54, 1'b1, '{'{1'b1, 16'd300, 1'b0}, '{1'b0, 16'd200, 1'b0},
                         '{1'b0, 16'd100, 1'b1}}},
        '{8'h41, 1'b0, '0},   // first letter
        '{8'h5A, 1'b0, '0},   // last letter
        '{8'h4B, 1'b0, '0},   // K, dash dot dash
        '{8'h51, 1'b0, '0},
        '{8'h59, 1'b0, '0},
        '{8'h42, 1'b0, '0},
        '{8'h40, 1'b0, '0},   // just below the letters
        '{8'h5B, 1'b0, '0},   // just above the letters
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h20, 1'b0, '0},
        '{8'h61, 1'b0, '0}    // lower case takes the space pattern
    };

    localparam logic [mck_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
        mck_pkg::REG_DOT, mck_pkg::REG_DASH, mck_pkg::REG_EGAP, mck_pkg::REG_CGAP
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [7:0]                    i_ascii_char;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_key_level;
    logic [mck_pkg::DATA_W-1:0]    o_duration_ms;
    logic                          o_last_segment;
    logic                          i_cfg_we;
    logic [mck_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mck_pkg::DATA_W-1:0]    i_cfg_data;

    // timing registers as the block should hold them
    logic [mck_pkg::DATA_W-1:0] dot_ms;
    logic [mck_pkg::DATA_W-1:0] dash_ms;
    logic [mck_pkg::DATA_W-1:0] egap_ms;
    logic [mck_pkg::DATA_W-1:0] cgap_ms;

    t_segment       keying_q [$];
    logic           typed_pending;
    t_segment [0:2] typed_segs;
    bit             steady_flow;
    int             err_count;
    int             char_count;
    int             seg_count;
    int             cycle_count;
    int             setting_count;

    morse_character_keyer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_ascii_char   (i_ascii_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_level    (o_key_level),
        .o_duration_ms  (o_duration_ms),
        .o_last_segment (o_last_segment),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic void predict_keying(input logic [7:0] ch);
        logic [7:0] code;
        int         n_elem;
        code = (ch >= mck_pkg::ASCII_A && ch <= mck_pkg::ASCII_Z) ?
               MORSE_CODE[ch - mck_pkg::ASCII_A] : MORSE_CODE[WORD_SPACE];
        n_elem = (int'(code[7:5]) < ELEM_CAP) ? int'(code[7:5]) : ELEM_CAP;
        for (int i = 0; i < n_elem; i++) begin
            keying_q.push_back('{1'b1, code[4-i] ? dash_ms : dot_ms, 1'b0});
            keying_q.push_back('{1'b0, egap_ms, 1'b0});
        end
        keying_q.push_back('{1'b0, cgap_ms, 1'b1});
    endfunction

    function automatic logic [mck_pkg::DATA_W-1:0] draw_ms();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return mck_pkg::DATA_W'($urandom_range(1, 15));
            default: return mck_pkg::DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // accepted transactions on both channels
    always @(posedge i_clk) begin
        t_segment exp_seg;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (typed_pending) begin
                    for (int k = 0; k < 3; k++) keying_q.push_back(typed_segs[k]);
                end else begin
                    predict_keying(i_ascii_char);
                end
            end
            if (o_out_valid && i_out_ready) begin
                seg_count++;
                if (keying_q.size() == 0) begin
                    $error("unexpected segment: key_level %0d duration_ms %0d last_segment %0d",
                           o_key_level, o_duration_ms, o_last_segment);
                    err_count++;
                end else begin
                    exp_seg = keying_q.pop_front();
                    if (o_key_level !== exp_seg.level) begin
                        $error("key_level: expected %0d, got %0d", exp_seg.level, o_key_level);
                        err_count++;
                    end
                    if (o_duration_ms !== exp_seg.dur) begin
                        $error("duration_ms: expected %0d, got %0d", exp_seg.dur, o_duration_ms);
                        err_count++;
                    end
                    if (o_last_segment !== exp_seg.last) begin
                        $error("last_segment: expected %0d, got %0d",
                               exp_seg.last, o_last_segment);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments outstanding",
                     cycle_count, keying_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side back-pressure
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic typed,
                             input t_segment [0:2] segs);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_pending = typed;
        typed_segs    = segs;
        i_in_valid   <= 1'b1;
        i_ascii_char <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        char_count++;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        logic [7:0] ch;
        for (int i = 0; i < n; i++) begin
            // mostly letters, the rest anywhere in the byte range
            if ($urandom_range(0, 3) != 0) begin
                ch = 8'($urandom_range(mck_pkg::ASCII_A, mck_pkg::ASCII_Z));
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            send_char(ch, 1'b0, '0);
        end
    endtask

    task automatic drain_keying();
        i_in_valid <= 1'b0;
        while (keying_q.size() != 0) @(negedge i_clk);
    endtask

    // block is idle here; writes all four registers in rotation from a random start
    task automatic set_timings(input logic [mck_pkg::DATA_W-1:0] dot,
                               input logic [mck_pkg::DATA_W-1:0] dash,
                               input logic [mck_pkg::DATA_W-1:0] egap,
                               input logic [mck_pkg::DATA_W-1:0] cgap);
        logic [mck_pkg::DATA_W-1:0] vals [4];
        int                         start;
        int                         r;
        vals  = '{dot, dash, egap, cgap};
        start = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            r = (start + k) % 4;
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_ORDER[r];
            i_cfg_data  <= vals[r];
            case (REG_ORDER[r])
                mck_pkg::REG_DOT:  dot_ms  = vals[r];
                mck_pkg::REG_DASH: dash_ms = vals[r];
                mck_pkg::REG_EGAP: egap_ms = vals[r];
                mck_pkg::REG_CGAP: cgap_ms = vals[r];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        setting_count++;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_ascii_char  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = mck_pkg::REG_DOT;
        i_cfg_data    = '0;
        typed_pending = 1'b0;
        typed_segs    = '0;
        steady_flow   = 1'b0;
        dot_ms        = mck_pkg::DOT_RESET;
        dash_ms       = mck_pkg::DASH_RESET;
        egap_ms       = mck_pkg::EGAP_RESET;
        cgap_ms       = mck_pkg::CGAP_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_char(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].segs);
        drain_keying();

        set_timings('0, '0, '0, '0);
        run_random(40);
        drain_keying();

        steady_flow = 1'b1;
        set_timings('1, '1, '1, '1);
        run_random(40);
        drain_keying();

        for (int p = 0; p < 5; p++) begin
            steady_flow = (p == 2);
            set_timings(draw_ms(), draw_ms(), draw_ms(), draw_ms());
            run_random(50);
            drain_keying();
        end

        repeat (20) @(negedge i_clk);
        $display("sent %0d characters (table plus random) under %0d timing settings",
                 char_count, setting_count + 1);
        $display("checked %0d keying segments, %0d mismatches", seg_count, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
